[rtl/upd_pkg.sv]
// Shared types, character codes and helper functions of the URL percent decoder.
package upd_pkg;

   // Widths and reset values
   localparam int BYTE_WIDTH          = 8;
   localparam int LENGTH_WIDTH        = 16;
   localparam int COUNT_WIDTH_DEFAULT = 16;
   localparam int RUN_MAX             = 3;
   localparam int RUN_LEN_WIDTH       = 2;
   localparam logic [LENGTH_WIDTH-1:0] MAX_LENGTH_RESET = 16'hFFFF;

   // Character codes
   localparam logic [BYTE_WIDTH-1:0] CHAR_PLUS    = 8'h2B;
   localparam logic [BYTE_WIDTH-1:0] CHAR_PERCENT = 8'h25;
   localparam logic [BYTE_WIDTH-1:0] CHAR_SPACE   = 8'h20;
   localparam logic [BYTE_WIDTH-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [BYTE_WIDTH-1:0] CHAR_NINE    = 8'h39;
   localparam logic [BYTE_WIDTH-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [BYTE_WIDTH-1:0] CHAR_LOWER_F = 8'h66;
   localparam logic [BYTE_WIDTH-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [BYTE_WIDTH-1:0] CHAR_UPPER_F = 8'h46;
   localparam logic [BYTE_WIDTH-1:0] HEX_LETTER_OFFSET = 8'd10;

   // Request payload
   typedef struct packed {
      logic [BYTE_WIDTH-1:0] in_byte;
      logic                  end_of_string;
   } req_type;

   // Response payload
   typedef struct packed {
      logic [BYTE_WIDTH-1:0]   out_byte;
      logic                    out_valid;
      logic                    last_of_run;
      logic                    string_done;
      logic [LENGTH_WIDTH-1:0] output_length;
   } rsp_type;

   // One decoded run: the bytes one request produced
   typedef struct packed {
      logic [RUN_MAX-1:0][BYTE_WIDTH-1:0] run_bytes;
      logic [RUN_LEN_WIDTH-1:0]           run_len;
      logic                               string_end;
   } run_type;

   // Hex digit decode result
   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } hex_type;

   function automatic hex_type hex_decode(input logic [BYTE_WIDTH-1:0] c);
      hex_type h;
      h.ok    = 1'b1;
      h.value = 4'd0;
      if (c inside {[CHAR_ZERO:CHAR_NINE]}) begin
         h.value = 4'(c - CHAR_ZERO);
      end else if (c inside {[CHAR_LOWER_A:CHAR_LOWER_F]}) begin
         h.value = 4'(c - CHAR_LOWER_A + HEX_LETTER_OFFSET);
      end else if (c inside {[CHAR_UPPER_A:CHAR_UPPER_F]}) begin
         h.value = 4'(c - CHAR_UPPER_A + HEX_LETTER_OFFSET);
      end else begin
         h.ok = 1'b0;
      end
      return h;
   endfunction

   function automatic logic [BYTE_WIDTH-1:0] plus_to_space(input logic [BYTE_WIDTH-1:0] c);
      return (c == CHAR_PLUS) ? CHAR_SPACE : c;
   endfunction

endpackage

[rtl/upd_front.sv]
// Front end: accepts encoded bytes, tracks escape and limit state, builds decoded runs.
module upd_front #(
   parameter int COUNT_WIDTH = upd_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  upd_pkg::req_type                   req_payload,
   input  logic                               csr_wr_en,
   input  logic [upd_pkg::LENGTH_WIDTH-1:0]   csr_wr_data,
   input  logic                               run_ready,
   output logic                               run_valid,
   output upd_pkg::run_type                   run_data,
   output logic [COUNT_WIDTH-1:0]             run_base
);

   localparam int CMP_WIDTH = (COUNT_WIDTH > upd_pkg::LENGTH_WIDTH) ?
                              COUNT_WIDTH : upd_pkg::LENGTH_WIDTH;

   logic [upd_pkg::LENGTH_WIDTH-1:0] max_ff, max_in;
   logic [COUNT_WIDTH-1:0]           cnt_ff, cnt_in;
   logic                             lim_ff, lim_in;
   logic                             esc_ff, esc_in;
   logic                             full_ff, full_in;
   logic [upd_pkg::BYTE_WIDTH-1:0]   la_byte_ff, la_byte_in;

   logic [COUNT_WIDTH-1:0]                           cnt_v;
   logic                                             lim_v, esc_v, full_v;
   logic [upd_pkg::BYTE_WIDTH-1:0]                   lab_v;
   logic [upd_pkg::RUN_MAX-1:0][upd_pkg::BYTE_WIDTH-1:0] bytes_v;
   logic [upd_pkg::RUN_LEN_WIDTH-1:0]                n_v;
   upd_pkg::hex_type                                 h1, h2;
   logic [upd_pkg::BYTE_WIDTH-1:0]                   x;
   logic                                             last;
   logic                                             accept;

   function automatic logic below_limit(input logic [COUNT_WIDTH-1:0] c,
                                        input logic [upd_pkg::LENGTH_WIDTH-1:0] m);
      return CMP_WIDTH'(c) < CMP_WIDTH'(m);
   endfunction

   assign req_ready = run_ready;
   assign accept    = req_valid & req_ready;
   assign x         = req_payload.in_byte;
   assign last      = req_payload.end_of_string;

   // Decode one request against the current escape state
   always_comb begin
      cnt_v   = cnt_ff;
      lim_v   = lim_ff;
      esc_v   = esc_ff;
      full_v  = full_ff;
      lab_v   = la_byte_ff;
      bytes_v = '0;
      n_v     = '0;
      h1      = upd_pkg::hex_decode(la_byte_ff);
      h2      = upd_pkg::hex_decode(x);

      if (esc_ff && !full_ff) begin
         // '%' seen, waiting for the first digit
         if (last) begin
            esc_v = 1'b0;
            bytes_v[n_v] = upd_pkg::CHAR_PERCENT;
            n_v = n_v + 2'd1;
            cnt_v = cnt_v + COUNT_WIDTH'(1);
            if (lim_v || !below_limit(cnt_v, max_ff)) begin
               lim_v = 1'b1;
            end else begin
               bytes_v[n_v] = upd_pkg::plus_to_space(x);
               n_v = n_v + 2'd1;
               cnt_v = cnt_v + COUNT_WIDTH'(1);
            end
         end else begin
            lab_v  = x;
            full_v = 1'b1;
         end
      end else if (esc_ff) begin
         // second digit arrives
         esc_v  = 1'b0;
         full_v = 1'b0;
         if (h1.ok && h2.ok) begin
            bytes_v[n_v] = {h1.value, h2.value};
            n_v = n_v + 2'd1;
            cnt_v = cnt_v + COUNT_WIDTH'(1);
         end else begin
            // bad escape: literal '%', then rescan the held byte and this one
            bytes_v[n_v] = upd_pkg::CHAR_PERCENT;
            n_v = n_v + 2'd1;
            cnt_v = cnt_v + COUNT_WIDTH'(1);
            if (last) begin
               if (lim_v || !below_limit(cnt_v, max_ff)) begin
                  lim_v = 1'b1;
               end else begin
                  bytes_v[n_v] = upd_pkg::plus_to_space(la_byte_ff);
                  n_v = n_v + 2'd1;
                  cnt_v = cnt_v + COUNT_WIDTH'(1);
               end
               if (lim_v || !below_limit(cnt_v, max_ff)) begin
                  lim_v = 1'b1;
               end else begin
                  bytes_v[n_v] = upd_pkg::plus_to_space(x);
                  n_v = n_v + 2'd1;
                  cnt_v = cnt_v + COUNT_WIDTH'(1);
               end
            end else if (lim_v || !below_limit(cnt_v, max_ff)) begin
               lim_v = 1'b1;
            end else if (la_byte_ff == upd_pkg::CHAR_PERCENT) begin
               // held byte opens a new escape, this byte is its first digit
               esc_v  = 1'b1;
               lab_v  = x;
               full_v = 1'b1;
            end else begin
               bytes_v[n_v] = upd_pkg::plus_to_space(la_byte_ff);
               n_v = n_v + 2'd1;
               cnt_v = cnt_v + COUNT_WIDTH'(1);
               if (lim_v || !below_limit(cnt_v, max_ff)) begin
                  lim_v = 1'b1;
               end else if (x == upd_pkg::CHAR_PERCENT) begin
                  esc_v  = 1'b1;
                  full_v = 1'b0;
               end else begin
                  bytes_v[n_v] = upd_pkg::plus_to_space(x);
                  n_v = n_v + 2'd1;
                  cnt_v = cnt_v + COUNT_WIDTH'(1);
               end
            end
         end
      end else begin
         // plain position
         if (lim_v || !below_limit(cnt_v, max_ff)) begin
            lim_v = 1'b1;
         end else if (x == upd_pkg::CHAR_PERCENT && !last) begin
            esc_v  = 1'b1;
            full_v = 1'b0;
         end else begin
            bytes_v[n_v] = upd_pkg::plus_to_space(x);
            n_v = n_v + 2'd1;
            cnt_v = cnt_v + COUNT_WIDTH'(1);
         end
      end
   end

   // Next state: load the limit on a configuration write; hold, advance, or clear at the end of a string
   always_comb begin
      max_in     = csr_wr_en ? csr_wr_data : max_ff;
      cnt_in     = cnt_ff;
      lim_in     = lim_ff;
      esc_in     = esc_ff;
      full_in    = full_ff;
      la_byte_in = la_byte_ff;
      if (accept) begin
         if (last) begin
            cnt_in     = '0;
            lim_in     = 1'b0;
            esc_in     = 1'b0;
            full_in    = 1'b0;
            la_byte_in = '0;
         end else begin
            cnt_in     = cnt_v;
            lim_in     = lim_v;
            esc_in     = esc_v;
            full_in    = full_v;
            la_byte_in = lab_v;
         end
      end
   end

   // Run handed to the queue; a byte that produces nothing is dropped unless it ends the string
   assign run_valid           = accept & ((n_v != '0) | last);
   assign run_data.run_bytes  = bytes_v;
   assign run_data.run_len    = n_v;
   assign run_data.string_end = last;
   assign run_base            = cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff     <= upd_pkg::MAX_LENGTH_RESET;
         cnt_ff     <= '0;
         lim_ff     <= 1'b0;
         esc_ff     <= 1'b0;
         full_ff    <= 1'b0;
         la_byte_ff <= '0;
      end else begin
         max_ff     <= max_in;
         cnt_ff     <= cnt_in;
         lim_ff     <= lim_in;
         esc_ff     <= esc_in;
         full_ff    <= full_in;
         la_byte_ff <= la_byte_in;
      end
   end

endmodule

[rtl/upd_queue.sv]
// Two-entry queue between the decode front end and the output back end.
module upd_queue #(
   parameter int DATA_WIDTH = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [DATA_WIDTH-1:0] in_data,
   output logic                  out_valid,
   input  logic                  out_pop,
   output logic [DATA_WIDTH-1:0] out_data
);

   logic [DATA_WIDTH-1:0] entry_ff [2];
   logic                  wr_ptr_ff, wr_ptr_in;
   logic                  rd_ptr_ff, rd_ptr_in;
   logic [1:0]            count_ff, count_in;
   logic                  push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign push      = in_valid & in_ready;
   assign pop       = out_pop & out_valid;

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

[rtl/upd_back.sv]
// Back end: splits each queued run into responses, one per cycle unless stalled, through the output register.
module upd_back #(
   parameter int COUNT_WIDTH = upd_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   run_valid,
   output logic                   run_pop,
   input  upd_pkg::run_type       run_data,
   input  logic [COUNT_WIDTH-1:0] run_base,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output upd_pkg::rsp_type       rsp_payload
);

   logic [upd_pkg::RUN_LEN_WIDTH-1:0] idx_ff, idx_in;
   logic                              valid_ff, valid_in;
   upd_pkg::rsp_type                  rsp_ff, rsp_in;
   logic                              load, final_item;
   logic                              marker;
   logic [COUNT_WIDTH-1:0]            len_sum;

   assign load       = run_valid & (~valid_ff | rsp_ready);
   assign marker     = (run_data.run_len == '0);
   assign final_item = marker | (idx_ff == run_data.run_len - 2'd1);
   assign len_sum    = run_base + COUNT_WIDTH'(idx_ff) + COUNT_WIDTH'(1);
   assign run_pop    = load & final_item;

   // Build the next response from the head run
   always_comb begin
      rsp_in = rsp_ff;
      if (load) begin
         rsp_in.last_of_run = final_item;
         rsp_in.string_done = final_item & run_data.string_end;
         if (marker) begin
            rsp_in.out_byte      = '0;
            rsp_in.out_valid     = 1'b0;
            rsp_in.output_length = upd_pkg::LENGTH_WIDTH'(run_base);
         end else begin
            rsp_in.out_byte      = run_data.run_bytes[idx_ff];
            rsp_in.out_valid     = 1'b1;
            rsp_in.output_length = upd_pkg::LENGTH_WIDTH'(len_sum);
         end
      end
   end

   // Item index within the run and output valid
   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         idx_in   = final_item ? '0 : idx_ff + 2'd1;
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

[rtl/url_percent_decoder_core.sv]
// Top level of the streaming form-style URL percent decoder.
// Takes one encoded byte per request and returns one to three decoded bytes per
// request ('+' to space, "%hh" to one byte, bad escapes passed through literally),
// or a bare end marker when the final byte of a string produces no data. A request
// is accepted every cycle while the two-entry run queue has room; the back end
// drains the queue through a single output register at one response per cycle
// while rsp_ready is high, and a stream of bytes giving at most one response each
// runs at one byte per cycle under that condition. Requests that only complete
// half of an escape produce no response. Configuration writes of the output
// limit are taken at any cycle the write enable is high.
module url_percent_decoder_core #(
   parameter int COUNT_WIDTH = upd_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  upd_pkg::req_type                 req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output upd_pkg::rsp_type                 rsp_payload,
   input  logic                             csr_wr_en,
   input  logic [upd_pkg::LENGTH_WIDTH-1:0] csr_wr_data
);

   localparam int RUN_WIDTH   = $bits(upd_pkg::run_type);
   localparam int ENTRY_WIDTH = COUNT_WIDTH + RUN_WIDTH;

   logic                   push_valid, push_ready;
   upd_pkg::run_type       push_run;
   logic [COUNT_WIDTH-1:0] push_base;
   logic                   head_valid, head_pop;
   logic [ENTRY_WIDTH-1:0] head_data;
   upd_pkg::run_type       head_run;
   logic [COUNT_WIDTH-1:0] head_base;

   upd_front #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .run_ready  (push_ready),
      .run_valid  (push_valid),
      .run_data   (push_run),
      .run_base   (push_base)
   );

   upd_queue #(
      .DATA_WIDTH(ENTRY_WIDTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .in_valid (push_valid),
      .in_ready (push_ready),
      .in_data  ({push_base, push_run}),
      .out_valid(head_valid),
      .out_pop  (head_pop),
      .out_data (head_data)
   );

   // Split the queue head back into run and base count
   assign head_run  = head_data[RUN_WIDTH-1:0];
   assign head_base = head_data[ENTRY_WIDTH-1:RUN_WIDTH];

   upd_back #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .run_valid  (head_valid),
      .run_pop    (head_pop),
      .run_data   (head_run),
      .run_base   (head_base),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

endmodule

[rtl/upd_checker.sv]
// Port-level checks of the URL percent decoder, bound to its top level.
module upd_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input upd_pkg::rsp_type rsp_payload
);

   // No response is pending right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // The end of a string always closes a run
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.string_done) |-> rsp_payload.last_of_run)
      else $error("string_done without last_of_run");

   // A bare end marker only ends a string and carries no byte
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.out_valid) |->
         (rsp_payload.string_done && rsp_payload.out_byte == '0))
      else $error("malformed end marker");

   // A stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("stalled response changed");

endmodule

bind url_percent_decoder_core upd_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_payload(rsp_payload)
);

[sim/tb_top.sv]
// Self-checking testbench for the streaming URL percent decoder core.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RESET_CYCLES   = 5;
   localparam int SETTLE_CYCLES  = 10;
   localparam int END_CYCLES     = 20;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int PHASE_REQUESTS = 42;
   localparam int RANDOM_PHASES  = 7;
   localparam int MAX_REPORTS    = 10;

   logic                             clock       = 1'b0;
   logic                             reset       = 1'b1;
   logic                             req_valid   = 1'b0;
   logic                             req_ready;
   upd_pkg::req_type                 req_payload = '0;
   logic                             rsp_valid;
   logic                             rsp_ready   = 1'b0;
   upd_pkg::rsp_type                 rsp_payload;
   logic                             csr_wr_en   = 1'b0;
   logic [upd_pkg::LENGTH_WIDTH-1:0] csr_wr_data = '0;

   url_percent_decoder_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #1 clock = ~clock;

   // Decoder state as the testbench tracks it
   logic [upd_pkg::BYTE_WIDTH-1:0]   held_byte;
   logic                             held_valid;
   logic                             escape_pending;
   logic                             limit_hit;
   logic [upd_pkg::LENGTH_WIDTH-1:0] decoded_count;
   logic [upd_pkg::LENGTH_WIDTH-1:0] length_limit;

   upd_pkg::rsp_type step_rsp_q[$];
   upd_pkg::rsp_type expected_rsp_q[$];
   upd_pkg::req_type pending_req_q[$];

   // Stimulus and checking bookkeeping
   bit               offer_busy   = 1'b0;
   bit               tx_quiet     = 1'b0;
   bit               rx_quiet     = 1'b0;
   bit               hold_request = 1'b0;
   int               tx_gap_left  = 0;
   int               stall_left   = 0;
   int               hold_left    = 0;
   int               idle_cycles  = 0;
   int               error_count  = 0;
   int               req_count    = 0;
   int               rsp_count    = 0;
   int               string_count = 0;
   int               marker_count = 0;
   int               limit_writes = 0;
   upd_pkg::req_type next_req;
   upd_pkg::rsp_type want;
   string            bad_fields;
   logic             rx_ready_next;

   function automatic int hex_nibble(input logic [upd_pkg::BYTE_WIDTH-1:0] c);
      if (c >= upd_pkg::CHAR_ZERO && c <= upd_pkg::CHAR_NINE)
         return int'(c - upd_pkg::CHAR_ZERO);
      if (c >= upd_pkg::CHAR_LOWER_A && c <= upd_pkg::CHAR_LOWER_F)
         return int'(c - upd_pkg::CHAR_LOWER_A) + 10;
      if (c >= upd_pkg::CHAR_UPPER_A && c <= upd_pkg::CHAR_UPPER_F)
         return int'(c - upd_pkg::CHAR_UPPER_A) + 10;
      return -1;
   endfunction

   function automatic void clear_string();
      held_byte      = '0;
      held_valid     = 1'b0;
      escape_pending = 1'b0;
      decoded_count  = '0;
      limit_hit      = 1'b0;
   endfunction

   // One decoded byte of the current request; a request yields at most three
   function automatic void put_byte(input logic [upd_pkg::BYTE_WIDTH-1:0] b);
      upd_pkg::rsp_type r;
      if (step_rsp_q.size() >= upd_pkg::RUN_MAX) return;
      decoded_count   = decoded_count + 1'b1;
      r               = '0;
      r.out_byte      = b;
      r.out_valid     = 1'b1;
      r.output_length = decoded_count;
      step_rsp_q.push_back(r);
   endfunction

   // Limit check taken before a byte is decoded as a new position
   function automatic bit slot_open();
      if (limit_hit || decoded_count >= length_limit) begin
         limit_hit = 1'b1;
         return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic void plain_position(input logic [upd_pkg::BYTE_WIDTH-1:0] b,
                                          input bit no_more);
      if (!slot_open()) return;
      if (b == upd_pkg::CHAR_PERCENT && !no_more) begin
         escape_pending = 1'b1;
         held_valid     = 1'b0;
         return;
      end
      put_byte((b == upd_pkg::CHAR_PLUS) ? upd_pkg::CHAR_SPACE : b);
   endfunction

   // Expected responses for one accepted request
   function automatic void decode_request(input upd_pkg::req_type r);
      logic [upd_pkg::BYTE_WIDTH-1:0] x;
      logic [upd_pkg::BYTE_WIDTH-1:0] b1;
      bit                             last_byte;
      int                             h1;
      int                             h2;
      upd_pkg::rsp_type               e;
      x         = r.in_byte;
      last_byte = r.end_of_string;
      step_rsp_q.delete();
      if (escape_pending && !held_valid) begin
         // first byte after a '%'
         if (last_byte) begin
            escape_pending = 1'b0;
            put_byte(upd_pkg::CHAR_PERCENT);
            plain_position(x, 1'b1);
         end else begin
            held_byte  = x;
            held_valid = 1'b1;
         end
      end else if (escape_pending) begin
         // second digit: decode, or fall back to a literal '%'
         b1             = held_byte;
         h1             = hex_nibble(b1);
         h2             = hex_nibble(x);
         escape_pending = 1'b0;
         held_valid     = 1'b0;
         if (h1 >= 0 && h2 >= 0) begin
            put_byte(8'((h1 << 4) | h2));
         end else begin
            put_byte(upd_pkg::CHAR_PERCENT);
            if (last_byte) begin
               plain_position(b1, 1'b1);
               plain_position(x, 1'b1);
            end else if (slot_open()) begin
               if (b1 == upd_pkg::CHAR_PERCENT) begin
                  escape_pending = 1'b1;
                  held_byte      = x;
                  held_valid     = 1'b1;
               end else begin
                  put_byte((b1 == upd_pkg::CHAR_PLUS) ? upd_pkg::CHAR_SPACE : b1);
                  plain_position(x, 1'b0);
               end
            end
         end
      end else begin
         plain_position(x, last_byte);
      end

      if (step_rsp_q.size() == 0) begin
         // a final byte with no data still closes the string
         if (last_byte) begin
            e               = '0;
            e.last_of_run   = 1'b1;
            e.string_done   = 1'b1;
            e.output_length = decoded_count;
            expected_rsp_q.push_back(e);
            clear_string();
         end
      end else begin
         for (int k = 0; k < step_rsp_q.size(); k++) begin
            e = step_rsp_q[k];
            if (k == step_rsp_q.size() - 1) begin
               e.last_of_run = 1'b1;
               e.string_done = last_byte;
            end
            expected_rsp_q.push_back(e);
         end
         if (last_byte) clear_string();
      end
   endfunction

   // Mostly no gap, often a short one, now and then a long one
   function automatic int pick_gap(input bit quiet);
      int roll;
      if (quiet) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic string describe(input upd_pkg::rsp_type r);
      return $sformatf("byte=%02h valid=%0d last=%0d done=%0d len=%0d",
                       r.out_byte, r.out_valid, r.last_of_run, r.string_done,
                       r.output_length);
   endfunction

   function automatic logic [upd_pkg::BYTE_WIDTH-1:0] hex_char(input int v);
      if (v < 10) return upd_pkg::CHAR_ZERO + 8'(v);
      return ($urandom_range(0, 1) ? upd_pkg::CHAR_UPPER_A : upd_pkg::CHAR_LOWER_A)
             + 8'(v - 10);
   endfunction

   task automatic push_req(input logic [upd_pkg::BYTE_WIDTH-1:0] b, input bit last_byte);
      upd_pkg::req_type r;
      r.in_byte       = b;
      r.end_of_string = last_byte;
      pending_req_q.push_back(r);
   endtask

   // Random string: mostly escapes, plus signs and text, some broken escapes and noise
   task automatic queue_random_string(input int max_len);
      logic [upd_pkg::BYTE_WIDTH-1:0] text[$];
      int                             len;
      int                             roll;
      len = $urandom_range(1, max_len);
      while (text.size() < len) begin
         roll = $urandom_range(0, 99);
         if (roll < 35) begin
            text.push_back(8'($urandom_range(8'h21, 8'h7E)));
         end else if (roll < 45) begin
            text.push_back(upd_pkg::CHAR_PLUS);
         end else if (roll < 75) begin
            text.push_back(upd_pkg::CHAR_PERCENT);
            text.push_back(hex_char($urandom_range(0, 15)));
            text.push_back(hex_char($urandom_range(0, 15)));
         end else if (roll < 85) begin
            text.push_back(upd_pkg::CHAR_PERCENT);
            if ($urandom_range(0, 1)) text.push_back(hex_char($urandom_range(0, 15)));
            else text.push_back(8'($urandom_range(0, 255)));
            text.push_back(8'($urandom_range(0, 255)));
         end else begin
            text.push_back(8'($urandom_range(0, 255)));
         end
      end
      // trimming can cut an escape short at the end of the string
      while (text.size() > len) void'(text.pop_back());
      foreach (text[k]) push_req(text[k], k == text.size() - 1);
   endtask

   task automatic write_limit(input logic [upd_pkg::LENGTH_WIDTH-1:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      length_limit  = value;
      limit_writes++;
   endtask

   // Wait until every request is taken and every response is back, then let the core settle
   task automatic wait_idle(input int extra);
      while (pending_req_q.size() != 0 || offer_busy || expected_rsp_q.size() != 0)
         @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   // Request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            decode_request(req_payload);
            req_count++;
            if (req_payload.end_of_string) string_count++;
            offer_busy  = 1'b0;
            tx_gap_left = pick_gap(tx_quiet);
         end
         if (!offer_busy) begin
            if (tx_gap_left > 0) begin
               tx_gap_left--;
            end else if (pending_req_q.size() != 0) begin
               next_req     = pending_req_q.pop_front();
               offer_busy   = 1'b1;
               req_payload <= next_req;
            end
         end
         req_valid <= offer_busy;
      end
   end

   // Response monitor and checker, with random stalls and the long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_count++;
            if (rsp_payload.string_done && !rsp_payload.out_valid) marker_count++;
            if (expected_rsp_q.size() == 0) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("unexpected response: %s", describe(rsp_payload));
            end else begin
               want       = expected_rsp_q.pop_front();
               bad_fields = "";
               if (rsp_payload.out_byte !== want.out_byte) bad_fields = {bad_fields, " out_byte"};
               if (rsp_payload.out_valid !== want.out_valid)
                  bad_fields = {bad_fields, " out_valid"};
               if (rsp_payload.last_of_run !== want.last_of_run)
                  bad_fields = {bad_fields, " last_of_run"};
               if (rsp_payload.string_done !== want.string_done)
                  bad_fields = {bad_fields, " string_done"};
               if (rsp_payload.output_length !== want.output_length)
                  bad_fields = {bad_fields, " output_length"};
               if (bad_fields != "") begin
                  error_count++;
                  if (error_count <= MAX_REPORTS)
                     $display("response %0d wrong in%s: expected %s, got %s", rsp_count,
                              bad_fields, describe(want), describe(rsp_payload));
               end
            end
            stall_left = pick_gap(rx_quiet);
         end
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rx_ready_next = 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rx_ready_next = 1'b0;
         end else begin
            rx_ready_next = 1'b1;
         end
         rsp_ready <= rx_ready_next;
      end
   end

   // Watchdog: too long without any handshake on either side
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no request or response moved for %0d cycles", WATCHDOG_LIMIT);
         $display("[url_percent_decoder_core] ERROR");
         $finish;
      end
   end

   // Stimulus sequence
   initial begin
      int                               max_len;
      logic [upd_pkg::LENGTH_WIDTH-1:0] phase_limit;
      length_limit = upd_pkg::MAX_LENGTH_RESET;
      clear_string();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // byte extremes, upper and lower hex digits
      push_req(8'h00, 1'b0);
      push_req(8'hFF, 1'b0);
      push_req(upd_pkg::CHAR_PERCENT, 1'b0);
      push_req("f", 1'b0);
      push_req("F", 1'b1);
      // '%' as the only byte, and '%' one before the end
      push_req(upd_pkg::CHAR_PERCENT, 1'b1);
      push_req(upd_pkg::CHAR_PERCENT, 1'b0);
      push_req("A", 1'b1);
      // "%%41": the second '%' starts a fresh escape
      push_req(upd_pkg::CHAR_PERCENT, 1'b0);
      push_req(upd_pkg::CHAR_PERCENT, 1'b0);
      push_req("4", 1'b0);
      push_req("1", 1'b1);
      // broken escapes that yield three bytes each, mid-string and at the end
      push_req(upd_pkg::CHAR_PERCENT, 1'b0);
      push_req(upd_pkg::CHAR_PLUS, 1'b0);
      push_req("z", 1'b0);
      push_req(upd_pkg::CHAR_PERCENT, 1'b0);
      push_req("g", 1'b0);
      push_req(upd_pkg::CHAR_PLUS, 1'b1);
      // leave an escape open across the limit change
      push_req(upd_pkg::CHAR_PERCENT, 1'b0);
      wait_idle(SETTLE_CYCLES);

      // escape passed the check before the limit dropped to zero, then a one-byte string cut to a bare end marker
      write_limit('0);
      push_req("4", 1'b0);
      push_req("1", 1'b1);
      push_req("a", 1'b1);
      wait_idle(SETTLE_CYCLES);

      // limit cuts the string short, the final byte gives a bare end marker
      write_limit(upd_pkg::LENGTH_WIDTH'(2));
      push_req("a", 1'b0);
      push_req("b", 1'b0);
      push_req("c", 1'b1);
      wait_idle(SETTLE_CYCLES);

      // random phases over a range of limits and idle patterns
      for (int i = 0; i < RANDOM_PHASES; i++) begin
         case (i)
            0, 6:    phase_limit = upd_pkg::MAX_LENGTH_RESET;
            1:       phase_limit = upd_pkg::LENGTH_WIDTH'(1);
            2:       phase_limit = upd_pkg::LENGTH_WIDTH'(5);
            3:       phase_limit = '0;
            4:       phase_limit = upd_pkg::LENGTH_WIDTH'($urandom_range(10, 30));
            default: phase_limit = upd_pkg::LENGTH_WIDTH'(3);
         endcase
         max_len  = (i == 4) ? 40 : 12;
         tx_quiet = (i == 2 || i == 6);
         rx_quiet = (i == 3 || i == 5);
         write_limit(phase_limit);
         while (pending_req_q.size() < PHASE_REQUESTS) queue_random_string(max_len);
         if (i == 1 || i == 6) hold_request = 1'b1;
         wait_idle(SETTLE_CYCLES);
      end

      wait_idle(END_CYCLES);
      if (expected_rsp_q.size() != 0) begin
         error_count++;
         $display("%0d expected responses never arrived", expected_rsp_q.size());
      end
      $display("Covered %0d requests in %0d strings with %0d limit settings,", req_count,
               string_count, limit_writes);
      $display("checked %0d responses (%0d bare end markers), %0d mismatches.", rsp_count,
               marker_count, error_count);
      if (error_count == 0) begin
         $display("[url_percent_decoder_core] OK");
      end else begin
         $display("[url_percent_decoder_core] ERROR");
      end
      $finish;
   end

endmodule
